@@ hw/rtl/tbp_pkg.sv @@
// Shared types, constants and helpers of the tournament branch predictor.
// No dependencies; tbp_regs, tbp_pipe and the top level import this package.
package tbp_pkg;

    localparam int TBP_INDEX_BITS = 12;

    // Predictor scheme codes held in the kind register.
    localparam logic [1:0] KIND_BIMODAL = 2'd0;
    localparam logic [1:0] KIND_LOCAL   = 2'd1;
    localparam logic [1:0] KIND_GSHARE  = 2'd2;
    localparam logic [1:0] KIND_TOURN   = 2'd3;
    localparam logic [1:0] KIND_RESET   = KIND_TOURN;

    localparam logic [1:0] CNT_MIN      = 2'd0;
    localparam logic [1:0] CNT_MAX      = 2'd3;
    localparam logic [1:0] CHOICE_RESET = 2'd2;

    // Register index of the kind register on the configuration port.
    localparam logic REG_KIND = 1'b0;

    typedef struct packed {
        logic chose_global;
        logic global_says_taken;
        logic local_says_taken;
        logic predict_taken;
    } tbp_result_t;

    // One saturating step of a 2-bit counter.
    function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
        logic [1:0] r;
        if (up) begin
            r = (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
        end else begin
            r = (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tbp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for every table of the predictor.
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/tbp_regs.sv @@
// APB-style configuration register file of the predictor (scheme select).
// Depends on tbp_pkg for the kind codes and register indexes.
module tbp_regs import tbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  kind
);

    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       wr_kind;

    // Word select only; the byte offset bits are ignored.
    assign wr_kind = psel && penable && pwrite && (paddr[2] == REG_KIND);

    always_comb begin
        kind_next = kind_reg;
        if (wr_kind) begin
            kind_next = pwdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_RESET;
        end else begin
            kind_reg <= kind_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KIND) ? {30'd0, kind_reg} : 32'd0;
    assign kind   = kind_reg;

endmodule

@@ hw/rtl/tbp_pipe.sv @@
// Three-stage table pipeline: history read, counter read, predict and train.
// Depends on tbp_pkg and tbp_ram; holds the clearing sweep and output register.
module tbp_pipe import tbp_pkg::*; #(
    parameter int INDEX_BITS = TBP_INDEX_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            kind,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [INDEX_BITS-1:0] s_pc,
    input  logic                  s_taken,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tbp_result_t           m_result
);

    localparam int DEPTH = 1 << INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] idx_t;

    // Clearing sweep and global history.
    logic [INDEX_BITS:0] clr_cnt_reg;
    logic                clearing;
    idx_t                clr_addr;
    idx_t                ghist_reg;

    logic adv;
    logic acc;
    logic use_local;
    logic use_global;
    logic use_ghist;

    // Stage 1.
    logic s1_valid_reg, s1_train_reg, s1_taken_reg;
    idx_t s1_pc_reg, s1_gidx_reg;
    idx_t s0_gidx;

    // Stage 2.
    logic s2_valid_reg, s2_train_reg, s2_taken_reg;
    idx_t s2_pc_reg, s2_lidx_reg, s2_gidx_reg;

    // Output register.
    logic        m_valid_reg;
    tbp_result_t m_result_reg;
    tbp_result_t res_next;

    // Local history table.
    idx_t lh_raddr, lh_rdata, lh_waddr, lh_wdata, s1_lh, s1_lidx;
    logic lh_we;
    logic lhb_valid_reg;
    idx_t lhb_addr_reg, lhb_data_reg;

    // Counter tables.
    idx_t       lc_raddr, gc_raddr, ch_raddr;
    idx_t       lc_waddr, gc_waddr, ch_waddr;
    logic [1:0] lc_rdata, gc_rdata, ch_rdata;
    logic [1:0] lc_wdata, gc_wdata, ch_wdata;
    logic       lc_we, gc_we, ch_we;
    logic [1:0] lc_val, gc_val, ch_val;
    logic       lcb_valid_reg, gcb_valid_reg, chb_valid_reg;
    idx_t       lcb_addr_reg, gcb_addr_reg, chb_addr_reg;
    logic [1:0] lcb_data_reg, gcb_data_reg, chb_data_reg;

    logic lpred, gpred, cgpred, lok, gok, s2_upd;

    assign clearing = !clr_cnt_reg[INDEX_BITS];
    assign clr_addr = clr_cnt_reg[INDEX_BITS-1:0];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !clearing;
    assign acc     = s_valid && s_ready;

    assign use_local  = (kind == KIND_LOCAL) || (kind == KIND_TOURN);
    assign use_global = (kind != KIND_LOCAL);
    assign use_ghist  = (kind == KIND_GSHARE) || (kind == KIND_TOURN);

    assign s0_gidx = (kind == KIND_BIMODAL) ? s_pc : (s_pc ^ ghist_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            ghist_reg   <= '0;
        end else begin
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (acc && s_op && use_ghist) begin
                ghist_reg <= {ghist_reg[INDEX_BITS-2:0], s_taken};
            end
        end
    end

    // Stage registers; all stages move together, held while the output stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_train_reg <= s_op;
            s1_taken_reg <= s_taken;
            s1_pc_reg    <= s_pc;
            s1_gidx_reg  <= s0_gidx;
            s2_train_reg <= s1_train_reg;
            s2_taken_reg <= s1_taken_reg;
            s2_pc_reg    <= s1_pc_reg;
            s2_lidx_reg  <= s1_lidx;
            s2_gidx_reg  <= s1_gidx_reg;
            m_result_reg <= res_next;
        end
    end

    // While stalled each table keeps reading the entry of the item that waits
    // on its data, so the registered read output stays valid.
    assign lh_raddr = adv ? s_pc : s1_pc_reg;
    assign lc_raddr = adv ? s1_lidx : s2_lidx_reg;
    assign gc_raddr = adv ? s1_gidx_reg : s2_gidx_reg;
    assign ch_raddr = adv ? s1_pc_reg : s2_pc_reg;

    // The last write to each table is kept so that a read issued at the same
    // edge as that write still sees the new value.
    assign s1_lh   = (lhb_valid_reg && lhb_addr_reg == s1_pc_reg) ? lhb_data_reg : lh_rdata;
    assign s1_lidx = s1_pc_reg ^ s1_lh;

    assign lc_val = (lcb_valid_reg && lcb_addr_reg == s2_lidx_reg) ? lcb_data_reg : lc_rdata;
    assign gc_val = (gcb_valid_reg && gcb_addr_reg == s2_gidx_reg) ? gcb_data_reg : gc_rdata;
    assign ch_val = (chb_valid_reg && chb_addr_reg == s2_pc_reg) ? chb_data_reg : ch_rdata;

    assign lpred  = lc_val[1];
    assign gpred  = gc_val[1];
    assign cgpred = ch_val[1];
    assign lok    = (lpred == s2_taken_reg);
    assign gok    = (gpred == s2_taken_reg);
    assign s2_upd = adv && s2_valid_reg && s2_train_reg;

    always_comb begin
        res_next = '0;
        case (kind)
            KIND_BIMODAL, KIND_GSHARE: begin
                res_next.predict_taken     = gpred;
                res_next.global_says_taken = gpred;
                res_next.chose_global      = 1'b1;
            end
            KIND_LOCAL: begin
                res_next.predict_taken    = lpred;
                res_next.local_says_taken = lpred;
            end
            default: begin
                res_next.predict_taken     = cgpred ? gpred : lpred;
                res_next.local_says_taken  = lpred;
                res_next.global_says_taken = gpred;
                res_next.chose_global      = cgpred;
            end
        endcase
    end

    // Write ports: the clearing sweep after reset, then training updates.
    always_comb begin
        if (clearing) begin
            lh_we = 1'b1;  lh_waddr = clr_addr;  lh_wdata = '0;
            lc_we = 1'b1;  lc_waddr = clr_addr;  lc_wdata = CNT_MIN;
            gc_we = 1'b1;  gc_waddr = clr_addr;  gc_wdata = CNT_MIN;
            ch_we = 1'b1;  ch_waddr = clr_addr;  ch_wdata = CHOICE_RESET;
        end else begin
            lh_we    = adv && s1_valid_reg && s1_train_reg && use_local;
            lh_waddr = s1_pc_reg;
            lh_wdata = {s1_lh[INDEX_BITS-2:0], s1_taken_reg};
            lc_we    = s2_upd && use_local;
            lc_waddr = s2_lidx_reg;
            lc_wdata = sat_move(lc_val, s2_taken_reg);
            gc_we    = s2_upd && use_global;
            gc_waddr = s2_gidx_reg;
            gc_wdata = sat_move(gc_val, s2_taken_reg);
            // The choice counter moves only when exactly one side was right.
            ch_we    = s2_upd && (kind == KIND_TOURN) && (gok != lok);
            ch_waddr = s2_pc_reg;
            ch_wdata = sat_move(ch_val, gok);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lhb_valid_reg <= 1'b0;
            lcb_valid_reg <= 1'b0;
            gcb_valid_reg <= 1'b0;
            chb_valid_reg <= 1'b0;
        end else begin
            if (lh_we) lhb_valid_reg <= 1'b1;
            if (lc_we) lcb_valid_reg <= 1'b1;
            if (gc_we) gcb_valid_reg <= 1'b1;
            if (ch_we) chb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (lh_we) begin
            lhb_addr_reg <= lh_waddr;
            lhb_data_reg <= lh_wdata;
        end
        if (lc_we) begin
            lcb_addr_reg <= lc_waddr;
            lcb_data_reg <= lc_wdata;
        end
        if (gc_we) begin
            gcb_addr_reg <= gc_waddr;
            gcb_data_reg <= gc_wdata;
        end
        if (ch_we) begin
            chb_addr_reg <= ch_waddr;
            chb_data_reg <= ch_wdata;
        end
    end

    tbp_ram #(.WIDTH(INDEX_BITS), .DEPTH(DEPTH)) u_local_hist (
        .aclk(aclk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_local_cnt (
        .aclk(aclk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
        .raddr(lc_raddr), .rdata(lc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_global_cnt (
        .aclk(aclk), .we(gc_we), .waddr(gc_waddr), .wdata(gc_wdata),
        .raddr(gc_raddr), .rdata(gc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_choice_cnt (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

@@ hw/rtl/tournament_branch_predictor.sv @@
// Top level of the tournament branch predictor: stream ports, config port.
// Depends on tbp_pkg, tbp_regs, tbp_pipe (and through it tbp_ram).
//
//   Channel   Direction  Handshake           Word
//   s_        in         s_tvalid/s_tready   branch and outcome, operation in tuser
//   m_        out        m_tvalid/m_tready   prediction flags
//   APB       in         psel/penable        kind register at byte address 0
//
// One word is taken every cycle unless the output stalls; each word passes through
// the local history read, then the counter reads, then predict and train, and its
// result is presented on m_ from the output register.
// After reset all 2**INDEX_BITS entries (4096 by default) of each table are swept
// to their reset values, one entry a cycle, while s_tready stays low.
// A stalled result holds the whole pipeline; s_tready then follows m_tready.
module tournament_branch_predictor import tbp_pkg::*; #(
    parameter int INDEX_BITS = TBP_INDEX_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // branch_pc[31:0], taken[32], zero pad
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // predict_taken, local_says_taken,
                                   // global_says_taken, chose_global, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  kind;
    tbp_result_t result;

    tbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .kind    (kind)
    );

    tbp_pipe #(.INDEX_BITS(INDEX_BITS)) u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .kind     (kind),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_op     (s_tuser[0]),
        .s_pc     (s_tdata[INDEX_BITS-1:0]),
        .s_taken  (s_tdata[32]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {4'd0, result};

endmodule
